@@ src/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies; used by every module of the converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int unsigned IN_W    = 16;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned HUE_W   = 9;
    localparam int unsigned DEG_W   = 6;

    localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
    // floor(u / 360) for 16-bit u: (u * HUE_RECIP) >> 24
    localparam logic [15:0]       HUE_RECIP    = 16'd46604;
    // 32768 mod 360, removes the sign offset of the hue
    localparam logic [HUE_W-1:0]  HUE_BIAS     = 9'd8;
    localparam logic [HUE_W-1:0]  HUE_TURN_LESS_BIAS = 9'd352;
    // floor(255 * p / 100): (p * PCT_RECIP) >> 22
    localparam logic [23:0]       PCT_RECIP    = 24'd10695720;
    // floor(y / 255) for y below 65536: (y * DIV255_RECIP) >> 24
    localparam logic [16:0]       DIV255_RECIP = 17'd65794;
    localparam logic [16:0]       CEIL255_ADD  = 17'd254;
    // floor(z / 60) for 14-bit z: (z * DIV60_RECIP) >> 20
    localparam logic [14:0]       DIV60_RECIP  = 15'd17477;

    localparam logic [HUE_W-1:0]  DEG_60  = 9'd60;
    localparam logic [HUE_W-1:0]  DEG_120 = 9'd120;
    localparam logic [HUE_W-1:0]  DEG_180 = 9'd180;
    localparam logic [HUE_W-1:0]  DEG_240 = 9'd240;
    localparam logic [HUE_W-1:0]  DEG_300 = 9'd300;
    localparam logic [HUE_W-1:0]  DEG_360 = 9'd360;

    typedef enum logic [2:0] {
        SEC_RED_GREEN_RISE  = 3'd0,
        SEC_RED_FALL        = 3'd1,
        SEC_BLUE_RISE       = 3'd2,
        SEC_GREEN_FALL      = 3'd3,
        SEC_RED_RISE        = 3'd4,
        SEC_BLUE_FALL       = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CODE_W-1:0] sat;
        logic [CODE_W-1:0] val;
        logic [CODE_W-1:0] alpha;
    } prep_t;

    typedef struct packed {
        sector_t           sector;
        logic [DEG_W-1:0]  offset;
        logic [CODE_W-1:0] hi;
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] span;
        logic [CODE_W-1:0] alpha;
    } chroma_t;

    typedef struct packed {
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] blue;
        logic [CODE_W-1:0] alpha;
    } rgba_t;

endpackage

@@ src/hsv2rgb_prep.sv @@
// Front end: hue wrap into 0..359 and percent clamp and scale to 8-bit codes.
// Two register stages. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_prep (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]    in_hue,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]    in_sat,
    input  logic signed [hsv2rgb_pkg::IN_W-1:0]    in_val,
    input  logic [hsv2rgb_pkg::CODE_W-1:0]         in_alpha,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output hsv2rgb_pkg::prep_t                     out_data
);

    function automatic logic [hsv2rgb_pkg::PCT_W-1:0] clamp_pct(
        input logic signed [hsv2rgb_pkg::IN_W-1:0] x
    );
        logic [hsv2rgb_pkg::PCT_W-1:0] r;
        if (x[hsv2rgb_pkg::IN_W-1]) begin
            r = '0;
        end else if (x > $signed({1'b0, 8'd0, hsv2rgb_pkg::PCT_MAX})) begin
            r = hsv2rgb_pkg::PCT_MAX;
        end else begin
            r = x[hsv2rgb_pkg::PCT_W-1:0];
        end
        return r;
    endfunction

    logic                            a_vld_reg, a_vld_next;
    logic [hsv2rgb_pkg::PCT_W-1:0]   a_sat_reg, a_val_reg;
    logic [15:0]                     a_hue_reg;
    logic [7:0]                      a_quo_reg;
    logic [hsv2rgb_pkg::CODE_W-1:0]  a_alpha_reg;
    logic                            b_vld_reg, b_vld_next;
    hsv2rgb_pkg::prep_t              b_data_reg, b_data_next;

    logic        a_en, b_en;
    logic [15:0] hue_off;
    logic [31:0] quo_prod;
    logic [16:0] quo_x360;
    logic [15:0] rem_full;
    logic [hsv2rgb_pkg::HUE_W-1:0] rem;
    logic [30:0] sat_prod, val_prod;

    assign b_en     = !b_vld_reg || out_ready;
    assign a_en     = !a_vld_reg || b_en;
    assign in_ready = a_en;

    // stage A: clamp, offset the hue to unsigned and estimate the turn count
    assign hue_off  = {~in_hue[15], in_hue[14:0]};
    assign quo_prod = hue_off * hsv2rgb_pkg::HUE_RECIP;

    always_comb begin
        a_vld_next = a_en ? in_valid : a_vld_reg;
        b_vld_next = b_en ? a_vld_reg : b_vld_reg;
    end

    // stage B: remainder, bias removal, percent scaling
    assign quo_x360 = {1'b0, a_quo_reg, 8'd0} + {3'd0, a_quo_reg, 6'd0}
                    + {4'd0, a_quo_reg, 5'd0} + {6'd0, a_quo_reg, 3'd0};
    assign rem_full = a_hue_reg - quo_x360[15:0];
    assign rem      = rem_full[hsv2rgb_pkg::HUE_W-1:0];
    assign sat_prod = a_sat_reg * hsv2rgb_pkg::PCT_RECIP;
    assign val_prod = a_val_reg * hsv2rgb_pkg::PCT_RECIP;

    always_comb begin
        b_data_next = b_data_reg;
        if (b_en) begin
            if (rem < hsv2rgb_pkg::HUE_BIAS) begin
                b_data_next.hue = rem + hsv2rgb_pkg::HUE_TURN_LESS_BIAS;
            end else begin
                b_data_next.hue = rem - hsv2rgb_pkg::HUE_BIAS;
            end
            b_data_next.sat   = sat_prod[29:22];
            b_data_next.val   = val_prod[29:22];
            b_data_next.alpha = a_alpha_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_sat_reg   <= clamp_pct(in_sat);
            a_val_reg   <= clamp_pct(in_val);
            a_hue_reg   <= hue_off;
            a_quo_reg   <= quo_prod[31:24];
            a_alpha_reg <= in_alpha;
        end
        b_data_reg <= b_data_next;
    end

    assign out_valid = b_vld_reg;
    assign out_data  = b_data_reg;

endmodule

@@ src/hsv2rgb_chroma.sv @@
// Middle: chroma span from saturation and value, min level, hue sector decode.
// Two register stages. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_chroma (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hsv2rgb_pkg::prep_t     in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hsv2rgb_pkg::chroma_t   out_data
);

    logic                            c_vld_reg, c_vld_next;
    logic [15:0]                     c_prod_reg;
    logic [hsv2rgb_pkg::HUE_W-1:0]   c_hue_reg;
    logic [hsv2rgb_pkg::CODE_W-1:0]  c_hi_reg;
    logic [hsv2rgb_pkg::CODE_W-1:0]  c_alpha_reg;
    logic                            d_vld_reg, d_vld_next;
    hsv2rgb_pkg::chroma_t            d_data_reg, d_data_next;

    logic        c_en, d_en;
    logic [16:0] ceil_num;
    logic [33:0] ceil_prod;
    logic [hsv2rgb_pkg::CODE_W-1:0] span;
    hsv2rgb_pkg::sector_t           sector;
    logic [hsv2rgb_pkg::HUE_W-1:0]  offset_full;

    assign d_en     = !d_vld_reg || out_ready;
    assign c_en     = !c_vld_reg || d_en;
    assign in_ready = c_en;

    always_comb begin
        c_vld_next = c_en ? in_valid : c_vld_reg;
        d_vld_next = d_en ? c_vld_reg : d_vld_reg;
    end

    // span = ceil(s8 * max / 255)
    assign ceil_num  = {1'b0, c_prod_reg} + hsv2rgb_pkg::CEIL255_ADD;
    assign ceil_prod = ceil_num * hsv2rgb_pkg::DIV255_RECIP;
    assign span      = ceil_prod[31:24];

    always_comb begin
        if (c_hue_reg <= hsv2rgb_pkg::DEG_60) begin
            sector      = hsv2rgb_pkg::SEC_RED_GREEN_RISE;
            offset_full = c_hue_reg;
        end else if (c_hue_reg <= hsv2rgb_pkg::DEG_120) begin
            sector      = hsv2rgb_pkg::SEC_RED_FALL;
            offset_full = hsv2rgb_pkg::DEG_120 - c_hue_reg;
        end else if (c_hue_reg <= hsv2rgb_pkg::DEG_180) begin
            sector      = hsv2rgb_pkg::SEC_BLUE_RISE;
            offset_full = c_hue_reg - hsv2rgb_pkg::DEG_120;
        end else if (c_hue_reg <= hsv2rgb_pkg::DEG_240) begin
            sector      = hsv2rgb_pkg::SEC_GREEN_FALL;
            offset_full = hsv2rgb_pkg::DEG_240 - c_hue_reg;
        end else if (c_hue_reg <= hsv2rgb_pkg::DEG_300) begin
            sector      = hsv2rgb_pkg::SEC_RED_RISE;
            offset_full = c_hue_reg - hsv2rgb_pkg::DEG_240;
        end else begin
            sector      = hsv2rgb_pkg::SEC_BLUE_FALL;
            offset_full = hsv2rgb_pkg::DEG_360 - c_hue_reg;
        end
    end

    always_comb begin
        d_data_next = d_data_reg;
        if (d_en) begin
            d_data_next.sector = sector;
            d_data_next.offset = offset_full[hsv2rgb_pkg::DEG_W-1:0];
            d_data_next.hi     = c_hi_reg;
            d_data_next.lo     = c_hi_reg - span;
            d_data_next.span   = span;
            d_data_next.alpha  = c_alpha_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            c_vld_reg <= c_vld_next;
            d_vld_reg <= d_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_prod_reg  <= in_data.sat * in_data.val;
            c_hue_reg   <= in_data.hue;
            c_hi_reg    <= in_data.val;
            c_alpha_reg <= in_data.alpha;
        end
        d_data_reg <= d_data_next;
    end

    assign out_valid = d_vld_reg;
    assign out_data  = d_data_reg;

endmodule

@@ src/hsv2rgb_blend.sv @@
// Back end: interpolated channel level and channel routing by sector.
// Two register stages, the last one is the output register. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_blend (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hsv2rgb_pkg::chroma_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hsv2rgb_pkg::rgba_t     out_data
);

    logic                            e_vld_reg, e_vld_next;
    logic [13:0]                     e_prod_reg;
    hsv2rgb_pkg::sector_t            e_sector_reg;
    logic [hsv2rgb_pkg::CODE_W-1:0]  e_hi_reg, e_lo_reg, e_alpha_reg;
    logic                            f_vld_reg, f_vld_next;
    hsv2rgb_pkg::rgba_t              f_data_reg, f_data_next;

    logic        e_en, f_en;
    logic [28:0] div_prod;
    logic [hsv2rgb_pkg::CODE_W-1:0] mid;

    assign f_en     = !f_vld_reg || out_ready;
    assign e_en     = !e_vld_reg || f_en;
    assign in_ready = e_en;

    always_comb begin
        e_vld_next = e_en ? in_valid : e_vld_reg;
        f_vld_next = f_en ? e_vld_reg : f_vld_reg;
    end

    // mid = floor(offset * span / 60) + min
    assign div_prod = e_prod_reg * hsv2rgb_pkg::DIV60_RECIP;
    assign mid      = div_prod[27:20] + e_lo_reg;

    always_comb begin
        f_data_next = f_data_reg;
        if (f_en) begin
            f_data_next.alpha = e_alpha_reg;
            case (e_sector_reg)
                hsv2rgb_pkg::SEC_RED_GREEN_RISE: begin
                    f_data_next.red   = e_hi_reg;
                    f_data_next.green = mid;
                    f_data_next.blue  = e_lo_reg;
                end
                hsv2rgb_pkg::SEC_RED_FALL: begin
                    f_data_next.red   = mid;
                    f_data_next.green = e_hi_reg;
                    f_data_next.blue  = e_lo_reg;
                end
                hsv2rgb_pkg::SEC_BLUE_RISE: begin
                    f_data_next.red   = e_lo_reg;
                    f_data_next.green = e_hi_reg;
                    f_data_next.blue  = mid;
                end
                hsv2rgb_pkg::SEC_GREEN_FALL: begin
                    f_data_next.red   = e_lo_reg;
                    f_data_next.green = mid;
                    f_data_next.blue  = e_hi_reg;
                end
                hsv2rgb_pkg::SEC_RED_RISE: begin
                    f_data_next.red   = mid;
                    f_data_next.green = e_lo_reg;
                    f_data_next.blue  = e_hi_reg;
                end
                hsv2rgb_pkg::SEC_BLUE_FALL: begin
                    f_data_next.red   = e_hi_reg;
                    f_data_next.green = e_lo_reg;
                    f_data_next.blue  = mid;
                end
                default: begin
                    f_data_next.red   = e_hi_reg;
                    f_data_next.green = mid;
                    f_data_next.blue  = e_lo_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end else begin
            e_vld_reg <= e_vld_next;
            f_vld_reg <= f_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_en) begin
            e_prod_reg   <= in_data.offset * in_data.span;
            e_sector_reg <= in_data.sector;
            e_hi_reg     <= in_data.hi;
            e_lo_reg     <= in_data.lo;
            e_alpha_reg  <= in_data.alpha;
        end
        f_data_reg <= f_data_next;
    end

    assign out_valid = f_vld_reg;
    assign out_data  = f_data_reg;

endmodule

@@ src/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: three pipeline sections in a row.
// Depends on hsv2rgb_pkg, hsv2rgb_prep, hsv2rgb_chroma, hsv2rgb_blend.
//
//   side     ports                       beat contents (lowest bits first)
//   input    s_tvalid s_tready s_tdata   hue[15:0] sat[31:16] bri[47:32] alpha[55:48]
//   result   m_tvalid m_tready m_tdata   red[7:0] green[15:8] blue[23:16] alpha[31:24]
//
// One beat enters per clock unless back pressure from m_tready stalls the pipeline.
// Depth is six register stages: two in the hue/percent front end, two in the
// chroma section, two in the blend section, the last being the output register.
// Each stage holds its own valid bit and advances when empty or when the next
// stage advances, so back pressure fills bubbles before stopping s_tready.
// aresetn is synchronous, active low, and clears the valid bits only.
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // hue, saturation, brightness, alpha_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red, green, blue, alpha_out
);

    logic                 prep_valid, prep_ready;
    hsv2rgb_pkg::prep_t   prep_data;
    logic                 chroma_valid, chroma_ready;
    hsv2rgb_pkg::chroma_t chroma_data;
    hsv2rgb_pkg::rgba_t   rgba;

    hsv2rgb_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hue    (s_tdata[15:0]),
        .in_sat    (s_tdata[31:16]),
        .in_val    (s_tdata[47:32]),
        .in_alpha  (s_tdata[55:48]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    hsv2rgb_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (chroma_valid),
        .out_ready (chroma_ready),
        .out_data  (chroma_data)
    );

    hsv2rgb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chroma_valid),
        .in_ready  (chroma_ready),
        .in_data   (chroma_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgba)
    );

    assign m_tdata = {rgba.alpha, rgba.blue, rgba.green, rgba.red};

`ifndef SYNTHESIS
    a_hue_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        prep_valid |-> prep_data.hue < hsv2rgb_pkg::DEG_360)
        else $error("wrapped hue out of range");

    a_min_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        chroma_valid |-> (chroma_data.lo <= chroma_data.hi
                          && chroma_data.span == chroma_data.hi - chroma_data.lo))
        else $error("chroma min above max");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && prep_valid && chroma_valid))
        else $error("input stalled with room in the pipeline");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !prep_valid && !chroma_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for hsv_to_rgb_converter: directed and random colors,
// random idle cycles on both streams, one long output stall.
// Depends on hsv2rgb_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [7:0]  alpha;
        logic [15:0] bri;
        logic [15:0] sat;
        logic [15:0] hue;
    } hsv_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    hsv_beat_t   pending_colors[$];
    logic [31:0] expected_rgba[$];
    hsv_beat_t   offered_color;
    int          beats_sent   = 0;
    int          results_seen = 0;
    int          err_count    = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    string       lane_names[4] = '{"red", "green", "blue", "alpha_out"};
    int          edge_vals[10] = '{-32768, 32767, -1, 0, 1, 99, 100, 101, 105, -5};

    hsv_to_rgb_converter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // hue, saturation, brightness, alpha_in
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // red, green, blue, alpha_out
    );

    always #5 aclk = ~aclk;

    function automatic int clamp_pct(logic [15:0] raw);
        int x;
        x = int'($signed(raw));
        if (x < 0) return 0;
        if (x > 100) return 100;
        return x;
    endfunction

    // Returns {alpha, blue, green, red}, the layout of m_tdata.
    function automatic logic [31:0] hsv_to_rgba(hsv_beat_t beat);
        int h, s8, hi, lo, span, r, g, b;
        hsv2rgb_pkg::sector_t sec;
        h = int'($signed(beat.hue)) % 360;
        if (h < 0) h += 360;
        s8   = 255 * clamp_pct(beat.sat) / 100;
        hi   = 255 * clamp_pct(beat.bri) / 100;
        lo   = hi - (s8 * hi + 254) / 255;
        span = hi - lo;
        if (h <= 60)       sec = hsv2rgb_pkg::SEC_RED_GREEN_RISE;
        else if (h <= 120) sec = hsv2rgb_pkg::SEC_RED_FALL;
        else if (h <= 180) sec = hsv2rgb_pkg::SEC_BLUE_RISE;
        else if (h <= 240) sec = hsv2rgb_pkg::SEC_GREEN_FALL;
        else if (h <= 300) sec = hsv2rgb_pkg::SEC_RED_RISE;
        else               sec = hsv2rgb_pkg::SEC_BLUE_FALL;
        case (sec)
            hsv2rgb_pkg::SEC_RED_GREEN_RISE: begin
                r = hi; g = h * span / 60 + lo; b = lo;
            end
            hsv2rgb_pkg::SEC_RED_FALL: begin
                r = (120 - h) * span / 60 + lo; g = hi; b = lo;
            end
            hsv2rgb_pkg::SEC_BLUE_RISE: begin
                r = lo; g = hi; b = (h - 120) * span / 60 + lo;
            end
            hsv2rgb_pkg::SEC_GREEN_FALL: begin
                r = lo; g = (240 - h) * span / 60 + lo; b = hi;
            end
            hsv2rgb_pkg::SEC_RED_RISE: begin
                r = (h - 240) * span / 60 + lo; g = lo; b = hi;
            end
            default: begin
                r = hi; g = lo; b = (360 - h) * span / 60 + lo;
            end
        endcase
        return {beat.alpha, 8'(b), 8'(g), 8'(r)};
    endfunction

    function automatic void queue_color(int h, int s, int v, int a);
        hsv_beat_t beat;
        beat.hue   = 16'(h);
        beat.sat   = 16'(s);
        beat.bri   = 16'(v);
        beat.alpha = 8'(a);
        pending_colors.push_back(beat);
    endfunction

    // Drive input beats; no idling while beats 900..1199 go out.
    always @(posedge aclk) begin
        bit gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_rgba.push_back(hsv_to_rgba(offered_color));
                beats_sent <= beats_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                gap = (beats_sent < 900 || beats_sent >= 1200) && ($urandom_range(99) < 9);
                if (pending_colors.size() != 0 && !gap) begin
                    offered_color = pending_colors.pop_front();
                    s_tdata  <= offered_color;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random idling except while results 900..1199 go out, one long hold-off after 400 results.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= 400) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= (results_seen >= 900 && results_seen < 1200)
                        || ($urandom_range(99) >= 9);
        end
    end

    // Check each result beat against the oldest prediction.
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_rgba.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
                err_count++;
            end else begin
                want = expected_rgba.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                        $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                 lane_names[i], want[8*i +: 8], m_tdata[8*i +: 8]);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        int kind;
        // hue wrap and every sector border
        queue_color(0, 100, 100, 0);
        queue_color(360, 100, 100, 255);
        queue_color(-360, 100, 100, 1);
        queue_color(720, 100, 100, 128);
        queue_color(-32768, 100, 100, 85);
        queue_color(32767, 100, 100, 170);
        queue_color(-1, 80, 90, 7);
        queue_color(60, 100, 100, 0);
        queue_color(61, 75, 100, 0);
        queue_color(120, 100, 100, 0);
        queue_color(121, 50, 60, 0);
        queue_color(180, 100, 100, 0);
        queue_color(181, 30, 100, 0);
        queue_color(240, 100, 100, 0);
        queue_color(241, 100, 40, 0);
        queue_color(300, 100, 100, 0);
        queue_color(301, 67, 33, 0);
        queue_color(359, 100, 100, 0);
        // clamping extremes and grey
        queue_color(200, -32768, 32767, 255);
        queue_color(200, 32767, -32768, 255);
        queue_color(30, 101, 150, 255);
        queue_color(30, -1, 100, 255);
        queue_color(250, 0, 55, 255);
        queue_color(90, 100, 0, 255);
        for (int n = 0; n < 1700; n++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                queue_color($urandom_range(1079) - 360, $urandom_range(100),
                            $urandom_range(100), $urandom_range(255));
            end else if (kind < 85) begin
                queue_color($urandom_range(65535), edge_vals[$urandom_range(9)],
                            edge_vals[$urandom_range(9)], $urandom_range(255));
            end else begin
                queue_color($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(255));
            end
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_colors.size() != 0 || s_tvalid || expected_rgba.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0 && expected_rgba.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, expected_rgba.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
src/hsv2rgb_pkg.sv
src/hsv2rgb_prep.sv
src/hsv2rgb_chroma.sv
src/hsv2rgb_blend.sv
src/hsv_to_rgb_converter.sv
dv/tb.sv
